// ----- design/de_mutation_crossover_macros.svh -----
// ----------------------------------------------------------------------------
// de_mutation_crossover assertion macros
// shared concurrent assertion forms, clocked on clk and held off in reset
// ----------------------------------------------------------------------------
`ifndef DE_MUTATION_CROSSOVER_MACROS_SVH
`define DE_MUTATION_CROSSOVER_MACROS_SVH

// same-cycle implication
`define DMC_ASSERT_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define DMC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- design/dmc_pkg.sv -----
// ----------------------------------------------------------------------------
// dmc_pkg
// types, register codes and reset values of the trial element generator
// ----------------------------------------------------------------------------
`default_nettype none

package dmc_pkg;

	localparam int VAL_W      = 32;
	localparam int SCALE_W    = 18;
	localparam int RATE_W     = 17;
	localparam int DRAW_W     = 17;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	// mutation strategy codes
	typedef enum logic [1:0] {
		STRAT_RAND1     = 2'd0,
		STRAT_RAND2     = 2'd1,
		STRAT_CUR_RAND1 = 2'd2,
		STRAT_BEST1     = 2'd3
	} dmc_strategy_t;

	// register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_STRATEGY   = 3'd0,
		REG_SCALE      = 3'd1,
		REG_CROSS_RATE = 3'd2,
		REG_BOUND_LOW  = 3'd3,
		REG_BOUND_HIGH = 3'd4
	} dmc_reg_t;

	localparam dmc_strategy_t     RST_STRATEGY   = STRAT_RAND1;
	localparam logic [SCALE_W-1:0] RST_SCALE     = 18'd32768;
	localparam logic [RATE_W-1:0]  RST_CROSS_RATE = 17'd58982;
	localparam logic signed [VAL_W-1:0] RST_BOUND_LOW  = -32'sd6553600;
	localparam logic signed [VAL_W-1:0] RST_BOUND_HIGH = 32'sd6553600;

endpackage

`default_nettype wire

// ----- design/dmc_if.sv -----
// ----------------------------------------------------------------------------
// dmc stream interfaces
// valid/ready channels for operand words and trial words
// ----------------------------------------------------------------------------
`default_nettype none

interface dmc_in_if;
	logic                                valid;
	logic                                ready;
	logic signed [dmc_pkg::VAL_W-1:0]    target_value;
	logic signed [dmc_pkg::VAL_W-1:0]    base_value;
	logic signed [dmc_pkg::VAL_W-1:0]    first_plus;
	logic signed [dmc_pkg::VAL_W-1:0]    first_minus;
	logic signed [dmc_pkg::VAL_W-1:0]    second_plus;
	logic signed [dmc_pkg::VAL_W-1:0]    second_minus;
	logic        [dmc_pkg::DRAW_W-1:0]   cross_draw;
	logic                                forced_take;
	logic        [dmc_pkg::DRAW_W-1:0]   blend_draw;
	logic                                last_element;

	modport source (
		output valid, target_value, base_value, first_plus, first_minus,
		       second_plus, second_minus, cross_draw, forced_take, blend_draw,
		       last_element,
		input  ready
	);
	modport sink (
		input  valid, target_value, base_value, first_plus, first_minus,
		       second_plus, second_minus, cross_draw, forced_take, blend_draw,
		       last_element,
		output ready
	);
endinterface

interface dmc_out_if;
	logic                                valid;
	logic                                ready;
	logic signed [dmc_pkg::VAL_W-1:0]    trial_value;
	logic                                was_repaired;
	logic                                took_mutant;
	logic                                last_out;

	modport source (
		output valid, trial_value, was_repaired, took_mutant, last_out,
		input  ready
	);
	modport sink (
		input  valid, trial_value, was_repaired, took_mutant, last_out,
		output ready
	);
endinterface

`default_nettype wire

// ----- design/de_mutation_crossover.sv -----
// ----------------------------------------------------------------------------
// de_mutation_crossover: differential-evolution trial element, signed Q16.16
// path: stage 1, stage 2 and output registers lie between an accepted operand word and its trial word
// throughput: one word per cycle while the sink is ready, set by the two-stage multiply/sum pipeline
// reset: arst_n clears all valid flags and loads the register reset values
// ----------------------------------------------------------------------------
`default_nettype none

`include "de_mutation_crossover_macros.svh"

module de_mutation_crossover (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               cfg_wen,
	input  wire [dmc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire [dmc_pkg::CFG_DATA_W-1:0]     cfg_data,
	dmc_in_if.sink                            items,
	dmc_out_if.source                         results
);

	// product and accumulator widths: 19-bit signed coefficient times
	// 33-bit signed difference, three terms summed with headroom
	localparam int DIFF_W = dmc_pkg::VAL_W + 1;
	localparam int COEF_W = dmc_pkg::SCALE_W + 1;
	localparam int PROD_W = DIFF_W + COEF_W;
	localparam int ACC_W  = PROD_W + 2;
	localparam int RND_W  = ACC_W - 16;

	// ---------------------------------------------------------------- config
	dmc_pkg::dmc_strategy_t                strategy_q;
	logic [dmc_pkg::SCALE_W-1:0]           scale_q;
	logic [dmc_pkg::RATE_W-1:0]            rate_q;
	logic signed [dmc_pkg::VAL_W-1:0]      bound_low_q;
	logic signed [dmc_pkg::VAL_W-1:0]      bound_high_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strategy_q   <= dmc_pkg::RST_STRATEGY;
			scale_q      <= dmc_pkg::RST_SCALE;
			rate_q       <= dmc_pkg::RST_CROSS_RATE;
			bound_low_q  <= dmc_pkg::RST_BOUND_LOW;
			bound_high_q <= dmc_pkg::RST_BOUND_HIGH;
		end else if (cfg_wen) begin
			// unknown indexes fall through and are dropped
			unique case (cfg_index)
				dmc_pkg::REG_STRATEGY: begin
					strategy_q <= dmc_pkg::dmc_strategy_t'(cfg_data[1:0]);
				end
				dmc_pkg::REG_SCALE: begin
					scale_q <= cfg_data[dmc_pkg::SCALE_W-1:0];
				end
				dmc_pkg::REG_CROSS_RATE: begin
					rate_q <= cfg_data[dmc_pkg::RATE_W-1:0];
				end
				dmc_pkg::REG_BOUND_LOW: begin
					bound_low_q <= $signed(cfg_data[dmc_pkg::VAL_W-1:0]);
				end
				dmc_pkg::REG_BOUND_HIGH: begin
					bound_high_q <= $signed(cfg_data[dmc_pkg::VAL_W-1:0]);
				end
				default: begin
				end
			endcase
		end
	end

	// --------------------------------------------------------- flow control
	// each stage takes a word when it is empty or its successor moves,
	// so bubbles fill while the output register waits on the sink
	logic v_s1, v_s2, out_valid_q;
	logic rdy_s1, rdy_s2, rdy_out;

	assign rdy_out     = !out_valid_q || results.ready;
	assign rdy_s2      = !v_s2 || rdy_out;
	assign rdy_s1      = !v_s1 || rdy_s2;
	assign items.ready = rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (rdy_s1) begin
				v_s1 <= items.valid;
			end
			if (rdy_s2) begin
				v_s2 <= v_s1;
			end
			if (rdy_out) begin
				out_valid_q <= v_s2;
			end
		end
	end

	// ------------------------------------------------------ stage 1: inputs
	logic signed [dmc_pkg::VAL_W-1:0]  target_s1, base_s1;
	logic signed [dmc_pkg::VAL_W-1:0]  p1_s1, m1_s1, p2_s1, m2_s1;
	logic [dmc_pkg::DRAW_W-1:0]        cross_draw_s1, blend_draw_s1;
	logic                              forced_s1, last_s1;

	always_ff @(posedge clk) begin
		if (items.valid && rdy_s1) begin
			target_s1     <= items.target_value;
			base_s1       <= items.base_value;
			p1_s1         <= items.first_plus;
			m1_s1         <= items.first_minus;
			p2_s1         <= items.second_plus;
			m2_s1         <= items.second_minus;
			cross_draw_s1 <= items.cross_draw;
			forced_s1     <= items.forced_take;
			blend_draw_s1 <= items.blend_draw;
			last_s1       <= items.last_element;
		end
	end

	// differences, coefficient select and the two products
	//   prod1 = F * (P1 - M1) in every strategy
	//   prod2 = F * (P2 - M2), k * (B - T), F * (B - T) or nothing
	logic signed [DIFF_W-1:0] diff1, diff2, diff_bt, mul2_op;
	logic signed [COEF_W-1:0] coef_f, coef2;
	logic signed [PROD_W-1:0] prod1, prod2;
	logic signed [dmc_pkg::VAL_W-1:0] base_term;
	logic take;

	always_comb begin
		diff1   = DIFF_W'($signed({p1_s1[dmc_pkg::VAL_W-1], p1_s1}))
		        - DIFF_W'($signed({m1_s1[dmc_pkg::VAL_W-1], m1_s1}));
		diff2   = DIFF_W'($signed({p2_s1[dmc_pkg::VAL_W-1], p2_s1}))
		        - DIFF_W'($signed({m2_s1[dmc_pkg::VAL_W-1], m2_s1}));
		diff_bt = DIFF_W'($signed({base_s1[dmc_pkg::VAL_W-1], base_s1}))
		        - DIFF_W'($signed({target_s1[dmc_pkg::VAL_W-1], target_s1}));
		coef_f  = $signed({1'b0, scale_q});
		unique case (strategy_q)
			dmc_pkg::STRAT_RAND1: begin
				coef2     = coef_f;
				mul2_op   = '0;
				base_term = base_s1;
				take      = (cross_draw_s1 <= rate_q) || forced_s1;
			end
			dmc_pkg::STRAT_RAND2: begin
				coef2     = coef_f;
				mul2_op   = diff2;
				base_term = base_s1;
				take      = (cross_draw_s1 <= rate_q) || forced_s1;
			end
			dmc_pkg::STRAT_CUR_RAND1: begin
				// no crossover here, the mutant always goes out
				coef2     = $signed({{(COEF_W-dmc_pkg::DRAW_W){1'b0}}, blend_draw_s1});
				mul2_op   = diff_bt;
				base_term = target_s1;
				take      = 1'b1;
			end
			dmc_pkg::STRAT_BEST1: begin
				coef2     = coef_f;
				mul2_op   = diff_bt;
				base_term = target_s1;
				take      = (cross_draw_s1 <= rate_q) || forced_s1;
			end
			default: begin
				coef2     = coef_f;
				mul2_op   = '0;
				base_term = base_s1;
				take      = 1'b0;
			end
		endcase
		prod1 = coef_f * diff1;
		prod2 = coef2 * mul2_op;
	end

	// ---------------------------------------------------- stage 2: products
	logic signed [PROD_W-1:0]          prod1_s2, prod2_s2;
	logic signed [dmc_pkg::VAL_W-1:0]  base_s2, target_s2;
	logic                              take_s2, last_s2;

	always_ff @(posedge clk) begin
		if (v_s1 && rdy_s2) begin
			prod1_s2  <= prod1;
			prod2_s2  <= prod2;
			base_s2   <= base_term;
			target_s2 <= target_s1;
			take_s2   <= take;
			last_s2   <= last_s1;
		end
	end

	// sum with 32 fractional bits, round half up, saturate, repair, select
	logic signed [ACC_W-1:0]           acc;
	logic signed [RND_W-1:0]           rnd;
	logic signed [dmc_pkg::VAL_W-1:0]  sat, fix_lo, fix_hi, trial;
	logic signed [dmc_pkg::VAL_W:0]    sum_lo, sum_hi;
	logic                              repaired;

	always_comb begin
		acc = ACC_W'($signed({base_s2, 16'h0000}))
		    + ACC_W'(prod1_s2) + ACC_W'(prod2_s2)
		    + ACC_W'(32'sd32768);
		// dropping the low 16 bits of a signed value floors it
		rnd = acc[ACC_W-1:16];
		if (rnd > RND_W'($signed(32'h7fffffff))) begin
			sat = $signed(32'h7fffffff);
		end else if (rnd < RND_W'($signed(32'h80000000))) begin
			sat = $signed(32'h80000000);
		end else begin
			sat = rnd[dmc_pkg::VAL_W-1:0];
		end

		// out of bounds: move halfway toward the target; the upper test
		// sees the value after the lower repair, even with crossed bounds
		sum_lo   = (dmc_pkg::VAL_W+1)'(target_s2) + (dmc_pkg::VAL_W+1)'(bound_low_q);
		sum_hi   = (dmc_pkg::VAL_W+1)'(bound_high_q) + (dmc_pkg::VAL_W+1)'(target_s2);
		fix_lo   = sat;
		repaired = 1'b0;
		if (bound_low_q > sat) begin
			fix_lo   = sum_lo[dmc_pkg::VAL_W:1];
			repaired = 1'b1;
		end
		fix_hi = fix_lo;
		if (bound_high_q < fix_lo) begin
			fix_hi   = sum_hi[dmc_pkg::VAL_W:1];
			repaired = 1'b1;
		end

		// target kept: repair flag is meaningless and stays low
		if (take_s2) begin
			trial = fix_hi;
		end else begin
			trial    = target_s2;
			repaired = 1'b0;
		end
	end

	// ------------------------------------------------------ output register
	logic signed [dmc_pkg::VAL_W-1:0]  trial_q;
	logic                              repaired_q, took_q, last_q;

	always_ff @(posedge clk) begin
		if (v_s2 && rdy_out) begin
			trial_q    <= trial;
			repaired_q <= repaired;
			took_q     <= take_s2;
			last_q     <= last_s2;
		end
	end

	assign results.valid        = out_valid_q;
	assign results.trial_value  = trial_q;
	assign results.was_repaired = repaired_q;
	assign results.took_mutant  = took_q;
	assign results.last_out     = last_q;

	// ------------------------------------------------------------ assertions
	`DMC_ASSERT_IMPLY(a_repair_needs_mutant, out_valid_q && !took_q, !repaired_q,
		"repair flagged on a kept target")
	`DMC_ASSERT_NEXT(a_accept_fills_s1, items.valid && items.ready, v_s1,
		"accepted word did not land in stage 1")
	`DMC_ASSERT_NEXT(a_s2_moves_out, v_s2 && rdy_out, out_valid_q,
		"stage 2 word lost on its way to the output register")

endmodule

`default_nettype wire

// ----- dv/tb_de_mutation_crossover.sv -----
// ----------------------------------------------------------------------------
// tb_de_mutation_crossover
// drives operand words into the trial element generator under a series of
// register settings and checks every trial word against an in-bench predictor
// ----------------------------------------------------------------------------
`default_nettype none

module tb_de_mutation_crossover;
	timeunit 1ns;
	timeprecision 1ps;

	// depth of the block from operand word to trial word: stage 1, stage 2 and the output register
	localparam int LATENCY     = 3;
	// cycles with no word moving on either channel before the run is called hung
	localparam int STALL_LIMIT = 2000;
	localparam int RAND_PHASES = 12;
	localparam int PHASE_WORDS = 85;

	// register indexes the block does not decode
	localparam logic [dmc_pkg::CFG_IDX_W-1:0] REG_SPARE_A = 3'd5;
	localparam logic [dmc_pkg::CFG_IDX_W-1:0] REG_SPARE_B = 3'd6;
	localparam logic [dmc_pkg::CFG_IDX_W-1:0] REG_SPARE_C = 3'd7;

	// q16.16 helpers
	localparam logic signed [dmc_pkg::VAL_W-1:0] VMAX = 32'sh7FFFFFFF;
	localparam logic signed [dmc_pkg::VAL_W-1:0] VMIN = 32'sh80000000;
	localparam logic signed [dmc_pkg::VAL_W-1:0] ONE  = 32'sd65536;
	localparam longint Q_ONE      = 65536;
	localparam longint Q_HALF_LSB = 32768;
	localparam longint Q_MAX      = 64'sd2147483647;
	localparam longint Q_MIN      = -64'sd2147483648;
	localparam int FRAC_W         = 16;

	// draw values with a meaning of their own
	localparam logic [dmc_pkg::DRAW_W-1:0] DRAW_ZERO = 17'd0;
	localparam logic [dmc_pkg::DRAW_W-1:0] DRAW_UNIT = 17'd65536;
	localparam logic [dmc_pkg::DRAW_W-1:0] DRAW_TOP  = 17'd131071;

	typedef struct {
		logic signed [dmc_pkg::VAL_W-1:0] target_value;
		logic signed [dmc_pkg::VAL_W-1:0] base_value;
		logic signed [dmc_pkg::VAL_W-1:0] first_plus;
		logic signed [dmc_pkg::VAL_W-1:0] first_minus;
		logic signed [dmc_pkg::VAL_W-1:0] second_plus;
		logic signed [dmc_pkg::VAL_W-1:0] second_minus;
		logic [dmc_pkg::DRAW_W-1:0]       cross_draw;
		logic                             forced_take;
		logic [dmc_pkg::DRAW_W-1:0]       blend_draw;
		logic                             last_element;
	} operand_word_t;

	typedef struct {
		logic signed [dmc_pkg::VAL_W-1:0] trial_value;
		logic                             was_repaired;
		logic                             took_mutant;
		logic                             last_out;
	} trial_word_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_wen;
	logic [dmc_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [dmc_pkg::CFG_DATA_W-1:0] cfg_data;

	dmc_in_if  operand_ch();
	dmc_out_if trial_ch();

	de_mutation_crossover dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.items     (operand_ch),
		.results   (trial_ch)
	);

	always #2 clk = ~clk;

	// predictor copy of the register file
	dmc_pkg::dmc_strategy_t           cur_strategy;
	logic [dmc_pkg::SCALE_W-1:0]      cur_scale;
	logic [dmc_pkg::RATE_W-1:0]       cur_rate;
	logic signed [dmc_pkg::VAL_W-1:0] cur_low;
	logic signed [dmc_pkg::VAL_W-1:0] cur_high;

	trial_word_t pending_trials[$];
	int error_count = 0;

	// sender burst state
	int burst_left = 0;

	// receiver stall pattern, rotated each cycle and reloaded whenever the age counter wraps
	logic [15:0] stall_pattern = 16'hFFFF;
	logic [5:0]  pattern_age   = 6'd0;

	// ------------------------------------------------------------------
	// predictor: one trial word from one operand word and the registers
	// ------------------------------------------------------------------
	function automatic trial_word_t trial_of(input operand_word_t w);
		trial_word_t r;
		longint tv, bv, d1, d2, k, f, acc, x, lo, hi;
		tv = w.target_value;
		bv = w.base_value;
		d1 = longint'(w.first_plus) - longint'(w.first_minus);
		d2 = longint'(w.second_plus) - longint'(w.second_minus);
		k  = w.blend_draw;
		f  = cur_scale;
		lo = cur_low;
		hi = cur_high;
		// exact mutant with 32 fraction bits
		case (cur_strategy)
			dmc_pkg::STRAT_RAND1:     acc = bv * Q_ONE + f * d1;
			dmc_pkg::STRAT_RAND2:     acc = bv * Q_ONE + f * d1 + f * d2;
			dmc_pkg::STRAT_CUR_RAND1: acc = tv * Q_ONE + k * (bv - tv) + f * d1;
			default:                  acc = tv * Q_ONE + f * (bv - tv) + f * d1;
		endcase
		// current-to-rand has no crossover, the rest take on draw or forced index
		r.took_mutant  = (cur_strategy == dmc_pkg::STRAT_CUR_RAND1) ||
		                 (w.cross_draw <= cur_rate) || w.forced_take;
		r.was_repaired = 1'b0;
		r.last_out     = w.last_element;
		if (r.took_mutant) begin
			// round half up, then saturate
			x = (acc + Q_HALF_LSB) >>> FRAC_W;
			if (x > Q_MAX) x = Q_MAX;
			if (x < Q_MIN) x = Q_MIN;
			// low repair first, the high test sees the repaired value
			if (lo > x) begin
				x = (tv + lo) >>> 1;
				r.was_repaired = 1'b1;
			end
			if (hi < x) begin
				x = (hi + tv) >>> 1;
				r.was_repaired = 1'b1;
			end
			r.trial_value = x[dmc_pkg::VAL_W-1:0];
		end else begin
			r.trial_value = w.target_value;
		end
		return r;
	endfunction

	function automatic operand_word_t op(
		input logic signed [dmc_pkg::VAL_W-1:0] t, b, p1, m1, p2, m2,
		input logic [dmc_pkg::DRAW_W-1:0] draw, input logic forced,
		input logic [dmc_pkg::DRAW_W-1:0] k, input logic last);
		operand_word_t w;
		w.target_value = t;
		w.base_value   = b;
		w.first_plus   = p1;
		w.first_minus  = m1;
		w.second_plus  = p2;
		w.second_minus = m2;
		w.cross_draw   = draw;
		w.forced_take  = forced;
		w.blend_draw   = k;
		w.last_element = last;
		return w;
	endfunction

	// operand values: full range, near zero, extremes and hugging the bounds
	function automatic logic signed [dmc_pkg::VAL_W-1:0] random_value();
		logic signed [dmc_pkg::VAL_W-1:0] v;
		case ($urandom_range(0, 7))
			0, 1: v = $urandom();
			2, 3: v = $signed(32'($urandom_range(0, 26214400))) - 32'sd13107200;
			4:    v = $urandom_range(0, 1) ? VMAX : VMIN;
			5:    v = cur_low + $signed(32'($urandom_range(0, 8))) - 32'sd4;
			6:    v = cur_high + $signed(32'($urandom_range(0, 8))) - 32'sd4;
			default: v = $signed(32'($urandom_range(0, 255))) - 32'sd128;
		endcase
		return v;
	endfunction

	// draws cluster at the crossover threshold and at one, some above one
	function automatic logic [dmc_pkg::DRAW_W-1:0] random_draw();
		logic [dmc_pkg::DRAW_W-1:0] d;
		case ($urandom_range(0, 5))
			0: d = DRAW_ZERO;
			1: d = DRAW_UNIT;
			2: d = cur_rate;
			3: d = cur_rate + 17'd1;
			4: d = 17'($urandom_range(0, 65536));
			default: d = 17'($urandom_range(0, 131071));
		endcase
		return d;
	endfunction

	function automatic operand_word_t random_operands();
		return op(random_value(), random_value(), random_value(), random_value(),
			random_value(), random_value(), random_draw(),
			$urandom_range(0, 7) == 0, random_draw(), $urandom_range(0, 7) == 0);
	endfunction

	// ------------------------------------------------------------------
	// sender: one operand word per call, bursts with random gaps
	// ------------------------------------------------------------------
	task automatic send_word(input operand_word_t w);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
			if (gap > 0) begin
				operand_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		operand_ch.valid        <= 1'b1;
		operand_ch.target_value <= w.target_value;
		operand_ch.base_value   <= w.base_value;
		operand_ch.first_plus   <= w.first_plus;
		operand_ch.first_minus  <= w.first_minus;
		operand_ch.second_plus  <= w.second_plus;
		operand_ch.second_minus <= w.second_minus;
		operand_ch.cross_draw   <= w.cross_draw;
		operand_ch.forced_take  <= w.forced_take;
		operand_ch.blend_draw   <= w.blend_draw;
		operand_ch.last_element <= w.last_element;
		@(posedge clk);
		while (!operand_ch.ready) @(posedge clk);
		// accepted at this edge, predict with the registers now in force
		pending_trials.push_back(trial_of(w));
		burst_left--;
	endtask

	// hold the sender off until every trial word has come back
	task automatic drain_trials();
		operand_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending_trials.size() != 0) @(posedge clk);
	endtask

	task automatic write_reg(input logic [dmc_pkg::CFG_IDX_W-1:0] idx,
		input logic [dmc_pkg::CFG_DATA_W-1:0] data);
		cfg_wen   <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		case (idx)
			dmc_pkg::REG_STRATEGY:   cur_strategy = dmc_pkg::dmc_strategy_t'(data[1:0]);
			dmc_pkg::REG_SCALE:      cur_scale    = data[dmc_pkg::SCALE_W-1:0];
			dmc_pkg::REG_CROSS_RATE: cur_rate     = data[dmc_pkg::RATE_W-1:0];
			dmc_pkg::REG_BOUND_LOW:  cur_low      = data;
			dmc_pkg::REG_BOUND_HIGH: cur_high     = data;
			default: ;
		endcase
		cfg_wen <= 1'b0;
		@(posedge clk);
	endtask

	// idle the block, then load all five registers; narrow ones get junk above
	task automatic apply_setting(input dmc_pkg::dmc_strategy_t s,
		input logic [dmc_pkg::SCALE_W-1:0] scale,
		input logic [dmc_pkg::RATE_W-1:0] rate, input logic signed [dmc_pkg::VAL_W-1:0] lo,
		input logic signed [dmc_pkg::VAL_W-1:0] hi);
		logic [dmc_pkg::CFG_DATA_W-1:0] data;
		drain_trials();
		data = $urandom();
		data[1:0] = s;
		write_reg(dmc_pkg::REG_STRATEGY, data);
		data = $urandom();
		data[dmc_pkg::SCALE_W-1:0] = scale;
		write_reg(dmc_pkg::REG_SCALE, data);
		data = $urandom();
		data[dmc_pkg::RATE_W-1:0] = rate;
		write_reg(dmc_pkg::REG_CROSS_RATE, data);
		write_reg(dmc_pkg::REG_BOUND_LOW, lo);
		write_reg(dmc_pkg::REG_BOUND_HIGH, hi);
	endtask

	// ------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------

	// reset strategy, scale, rate and bounds, with the draw right at the rate
	task automatic test_reset_values();
		send_word(op(ONE, 2 * ONE, ONE, 0, 0, 0, 17'd58982, 1'b0, 0, 1'b0));
		send_word(op(0, 120 * ONE, 0, 0, 0, 0, 17'd58983, 1'b1, 0, 1'b0));
		send_word(op(ONE, -120 * ONE, 0, 0, 0, 0, DRAW_ZERO, 1'b0, 0, 1'b0));
		send_word(op(-2 * ONE, 0, 0, 0, 0, 0, 17'd58983, 1'b0, 0, 1'b1));
	endtask

	// writes to undecoded indexes must leave the registers alone
	task automatic test_spare_indexes();
		drain_trials();
		write_reg(REG_SPARE_A, $urandom());
		write_reg(REG_SPARE_B, $urandom());
		write_reg(REG_SPARE_C, $urandom());
		repeat (3) send_word(random_operands());
	endtask

	// hand-picked words for each strategy and each corner of the arithmetic
	task automatic test_corner_words();
		// rand/1 with open bounds: saturation both ways, rounding ties, target kept
		apply_setting(dmc_pkg::STRAT_RAND1, 18'd32768, 17'd32768, VMIN, VMAX);
		send_word(op(0, VMAX, VMAX, VMIN, 0, 0, DRAW_ZERO, 1'b1, 0, 1'b0));
		send_word(op(0, VMIN, VMIN, VMAX, 0, 0, DRAW_ZERO, 1'b0, 0, 1'b0));
		send_word(op(ONE, 5 * ONE, 1, 0, 0, 0, 17'd32768, 1'b0, 0, 1'b0));
		send_word(op(ONE, 5 * ONE, 0, 1, 0, 0, 17'd32769, 1'b1, 0, 1'b0));
		send_word(op(-7 * ONE, VMAX, VMAX, VMIN, 0, 0, DRAW_UNIT, 1'b0, 0, 1'b1));

		// rand/2 with scale above two and zero rate: both repairs, odd targets
		apply_setting(dmc_pkg::STRAT_RAND2, 18'd262143, 17'd0, -100 * ONE, 100 * ONE);
		send_word(op(-3, -150 * ONE, 0, 0, 0, 0, DRAW_ZERO, 1'b0, 0, 1'b0));
		send_word(op(5, 150 * ONE, 0, 0, 0, 0, DRAW_TOP, 1'b1, 0, 1'b0));
		send_word(op(0, 0, ONE, 0, ONE, 0, 17'd1, 1'b0, 0, 1'b0));
		send_word(op(3 * ONE, 0, VMAX, VMIN, VMIN, VMAX, DRAW_ZERO, 1'b0, 0, 1'b0));
		send_word(op(3 * ONE, ONE, 0, ONE, 0, ONE, DRAW_TOP, 1'b1, 0, 1'b1));

		// current-to-rand with zero scale: k at zero, one and above one
		apply_setting(dmc_pkg::STRAT_CUR_RAND1, 18'd0, 17'd0, VMIN, VMAX);
		send_word(op(VMAX, VMIN, VMAX, VMIN, 0, 0, DRAW_TOP, 1'b0, DRAW_ZERO, 1'b0));
		send_word(op(VMIN, VMAX, VMIN, VMAX, 0, 0, DRAW_TOP, 1'b0, DRAW_UNIT, 1'b0));
		send_word(op(0, ONE, 0, 0, 0, 0, DRAW_UNIT, 1'b0, DRAW_TOP, 1'b0));
		send_word(op(10 * ONE, -10 * ONE, VMAX, 0, 0, 0, DRAW_UNIT, 1'b0, 17'd32768,
			1'b1));

		// target-to-best with crossed bounds: both repairs fire in a row
		apply_setting(dmc_pkg::STRAT_BEST1, 18'd65536, 17'd65536, 100 * ONE, -100 * ONE);
		send_word(op(0, 0, 0, 0, 0, 0, DRAW_UNIT, 1'b0, 0, 1'b0));
		send_word(op(2 * ONE, 300 * ONE, 0, 0, 0, 0, DRAW_ZERO, 1'b0, 0, 1'b0));
		send_word(op(-ONE, VMIN, VMAX, VMIN, 0, 0, 17'd65537, 1'b0, 0, 1'b1));
	endtask

	// random words under a spread of settings, extremes among them
	task automatic test_random_settings();
		dmc_pkg::dmc_strategy_t s;
		logic [dmc_pkg::SCALE_W-1:0] scale;
		logic [dmc_pkg::RATE_W-1:0] rate;
		logic signed [dmc_pkg::VAL_W-1:0] lo, hi, swap;
		for (int p = 0; p < RAND_PHASES; p++) begin
			s = dmc_pkg::dmc_strategy_t'(p % 4);
			case (p)
				4: begin
					scale = 18'd0;      rate = 17'd0;      lo = VMIN; hi = VMAX;
				end
				5: begin
					scale = 18'd262143; rate = 17'd131071; lo = VMIN; hi = VMAX;
				end
				6: begin
					scale = 18'd131072; rate = 17'd65536;
					lo = dmc_pkg::RST_BOUND_LOW; hi = dmc_pkg::RST_BOUND_HIGH;
				end
				7: begin
					scale = 18'd1;      rate = 17'd1;      lo = 0;    hi = 0;
				end
				default: begin
					if (p < 4) begin
						scale = 18'($urandom_range(0, 131072));
						rate  = 17'($urandom_range(0, 65536));
						lo = -$signed(32'($urandom_range(65536, 19660800)));
						hi = $signed(32'($urandom_range(65536, 19660800)));
					end else begin
						scale = 18'($urandom_range(0, 262143));
						rate  = 17'($urandom_range(0, 131071));
						lo = $urandom();
						hi = $urandom();
						// one phase always runs with the bounds crossed
						if (p == 9 && lo < hi) begin
							swap = lo;
							lo   = hi;
							hi   = swap;
						end
					end
				end
			endcase
			apply_setting(s, scale, rate, lo, hi);
			for (int i = 0; i < PHASE_WORDS; i++) begin
				// now and then let the pipe run dry mid-phase
				if ($urandom_range(0, 99) == 0) drain_trials();
				send_word(random_operands());
			end
		end
	endtask

	// ------------------------------------------------------------------
	// receiver: ready follows the rotating stall pattern
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (pattern_age == 6'd0)
			stall_pattern <= ($urandom_range(0, 3) == 0) ?
				16'hFFFF : (16'($urandom()) | 16'h0001);
		else
			stall_pattern <= {stall_pattern[0], stall_pattern[15:1]};
		pattern_age   <= pattern_age + 6'd1;
		trial_ch.ready <= stall_pattern[0];
	end

	task automatic note_error(input string msg);
		error_count++;
		if (error_count <= 10) $display("%t  %s", $realtime, msg);
	endtask

	// ------------------------------------------------------------------
	// checker: each trial word against the oldest prediction
	// ------------------------------------------------------------------
	always @(posedge clk) begin : trial_check
		trial_word_t want;
		if (arst_n && trial_ch.valid && trial_ch.ready) begin
			if (pending_trials.size() == 0) begin
				note_error($sformatf("unexpected trial word value %0d",
					trial_ch.trial_value));
			end else begin
				want = pending_trials.pop_front();
				if (trial_ch.trial_value !== want.trial_value ||
				    trial_ch.was_repaired !== want.was_repaired ||
				    trial_ch.took_mutant !== want.took_mutant ||
				    trial_ch.last_out !== want.last_out)
					note_error($sformatf(
						"trial mismatch: exp value %0d rep %b mut %b last %b, got %0d %b %b %b",
						want.trial_value, want.was_repaired, want.took_mutant,
						want.last_out, trial_ch.trial_value, trial_ch.was_repaired,
						trial_ch.took_mutant, trial_ch.last_out));
			end
		end
	end

	// watchdog on cycles where no word moves on either channel
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((operand_ch.valid && operand_ch.ready) || (trial_ch.valid && trial_ch.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("tb_de_mutation_crossover: errors");
		$finish;
	end

	// ------------------------------------------------------------------
	// main sequence
	// ------------------------------------------------------------------
	initial begin
		// every operand and register input known from time zero
		arst_n                  <= 1'b0;
		cfg_wen                 <= 1'b0;
		cfg_index               <= dmc_pkg::REG_STRATEGY;
		cfg_data                <= '0;
		operand_ch.valid        <= 1'b0;
		operand_ch.target_value <= '0;
		operand_ch.base_value   <= '0;
		operand_ch.first_plus   <= '0;
		operand_ch.first_minus  <= '0;
		operand_ch.second_plus  <= '0;
		operand_ch.second_minus <= '0;
		operand_ch.cross_draw   <= '0;
		operand_ch.forced_take  <= 1'b0;
		operand_ch.blend_draw   <= '0;
		operand_ch.last_element <= 1'b0;

		// predictor starts from the reset register values
		cur_strategy = dmc_pkg::RST_STRATEGY;
		cur_scale    = dmc_pkg::RST_SCALE;
		cur_rate     = dmc_pkg::RST_CROSS_RATE;
		cur_low      = dmc_pkg::RST_BOUND_LOW;
		cur_high     = dmc_pkg::RST_BOUND_HIGH;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_values();
		test_spare_indexes();
		test_corner_words();
		test_random_settings();

		// let the last trial words out, then watch for strays
		drain_trials();
		repeat (LATENCY + 4) @(posedge clk);
		if (error_count == 0 && pending_trials.size() == 0)
			$display("tb_de_mutation_crossover: clean");
		else
			$display("tb_de_mutation_crossover: errors");
		$finish;
	end

endmodule

`default_nettype wire
